@@ rtl/core/mtmaf_pkg.sv @@
`timescale 1ns / 1ps
package mtmaf_pkg;

	// port width of the sample and result fields
	localparam int FIELD_BITS = 12;

	// per-stage control that rides along with each word
	typedef struct packed {
		logic vld;
		logic warm;
	} stage_ctl_t;

endpackage

@@ rtl/core/mtmaf_cell.sv @@
`timescale 1ns / 1ps
module mtmaf_cell #(
	parameter int              WIDTH     = 12,
	parameter logic [WIDTH-1:0] RESET_VAL = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= RESET_VAL;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

@@ rtl/core/mtmaf_median.sv @@
`timescale 1ns / 1ps
module mtmaf_median #(
	parameter int MEDIAN_TAPS = 5,
	parameter int SAMPLE_BITS = 12,
	parameter int START_LEVEL = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SAMPLE_BITS-1:0] median
);

	localparam int                   CELLS     = MEDIAN_TAPS - 1;
	localparam int                   RW        = $clog2(MEDIAN_TAPS);
	localparam logic [SAMPLE_BITS-1:0] START_VAL = SAMPLE_BITS'(START_LEVEL);
	localparam logic [RW-1:0]        MID       = RW'(MEDIAN_TAPS / 2);

	// v[0] is the incoming sample, v[k] the k-th newest stored one
	logic [SAMPLE_BITS-1:0] v    [MEDIAN_TAPS];
	logic [RW-1:0]          rank [MEDIAN_TAPS];

	assign v[0] = sample;

	for (genvar k = 0; k < CELLS; k++) begin : g_tap
		mtmaf_cell #(
			.WIDTH    (SAMPLE_BITS),
			.RESET_VAL(START_VAL)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.d     (v[k]),
			.q     (v[k+1])
		);
	end

	// rank with ties broken by position gives every entry a distinct rank
	always_comb begin
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < MEDIAN_TAPS; j++) begin
				if (j != i) begin
					if ((v[j] < v[i]) || ((j < i) && (v[j] == v[i]))) begin
						rank[i] = rank[i] + RW'(1);
					end
				end
			end
		end
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			if (rank[i] == MID) begin
				median = median | v[i];
			end
		end
	end

endmodule

@@ rtl/core/mtmaf_average.sv @@
`timescale 1ns / 1ps
module mtmaf_average #(
	parameter int AVERAGE_TAPS = 8,
	parameter int SAMPLE_BITS  = 12,
	parameter int START_LEVEL  = 2048,
	parameter int TOTAL_BITS   = 15
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   update,
	input  logic [SAMPLE_BITS-1:0] median,
	output logic [TOTAL_BITS-1:0]  total_nxt
);

	localparam logic [SAMPLE_BITS-1:0] START_VAL = SAMPLE_BITS'(START_LEVEL);
	localparam longint unsigned        START_TOT = longint'(START_VAL) * AVERAGE_TAPS;
	localparam longint unsigned        MAX_TOT   =
		((longint'(1) << SAMPLE_BITS) - 1) * AVERAGE_TAPS;

	logic [SAMPLE_BITS-1:0] line [AVERAGE_TAPS+1];
	logic [TOTAL_BITS-1:0]  total_q;

	assign line[0] = median;

	for (genvar k = 0; k < AVERAGE_TAPS; k++) begin : g_tap
		mtmaf_cell #(
			.WIDTH    (SAMPLE_BITS),
			.RESET_VAL(START_VAL)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (update),
			.d     (line[k]),
			.q     (line[k+1])
		);
	end

	// oldest entry leaves, new median enters
	assign total_nxt = total_q - TOTAL_BITS'(line[AVERAGE_TAPS]) + TOTAL_BITS'(median);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_BITS'(START_TOT);
		end else if (update) begin
			total_q <= total_nxt;
		end
	end

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		longint'(total_q) <= MAX_TOT)
		else $error("running total above full scale");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		!update |=> $stable(total_q))
		else $error("running total moved without an update");

endmodule

@@ rtl/core/median_then_moving_average_filter.sv @@
`timescale 1ns / 1ps
// Median-then-moving-average filter for one converter channel. Takes one
// sample word per clock while in_stall is low; each result passes through the
// registered median, running sum, reciprocal multiply and output register
// stages in that order. The first MEDIAN_TAPS samples after reset only
// fill the median window and come back raw with warming_up set. After that,
// each sample joins the window of the newest MEDIAN_TAPS samples, the window
// median enters an AVERAGE_TAPS deep moving average that starts at
// START_LEVEL, and filtered is its truncated mean. Bits of sample above
// SAMPLE_BITS are ignored. A stall on the output only stops the input once
// every stage holds a word.
module median_then_moving_average_filter
	import mtmaf_pkg::*;
#(
	parameter int MEDIAN_TAPS  = 5,
	parameter int AVERAGE_TAPS = 8,
	parameter int START_LEVEL  = 2048,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FIELD_BITS-1:0] sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FIELD_BITS-1:0] filtered,
	output logic                  warming_up
);

	localparam int              WCW        = $clog2(MEDIAN_TAPS + 1);
	localparam logic [WCW-1:0]  WARM_DONE  = WCW'(MEDIAN_TAPS);
	localparam int              TOTAL_BITS = SAMPLE_BITS + $clog2(AVERAGE_TAPS);
	// q = (t * RECIP) >> SHIFT is exact for every reachable total
	localparam int              SHIFT      = TOTAL_BITS + $clog2(AVERAGE_TAPS);
	localparam int              RECIP_BITS = TOTAL_BITS + 1;
	localparam longint unsigned RECIP_VAL  =
		((longint'(1) << SHIFT) + AVERAGE_TAPS - 1) / AVERAGE_TAPS;
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);
	localparam int              PROD_BITS  = TOTAL_BITS + RECIP_BITS;

	logic [SAMPLE_BITS-1:0] s_in;
	logic [SAMPLE_BITS-1:0] med;
	logic [TOTAL_BITS-1:0]  total_nxt;
	logic [WCW-1:0]         warm_cnt_q;
	logic                   warm_now;

	stage_ctl_t             ctl_s1, ctl_s2, ctl_s3;
	logic [FIELD_BITS-1:0]  raw_s1, raw_s2, raw_s3;
	logic [SAMPLE_BITS-1:0] med_s1;
	logic [TOTAL_BITS-1:0]  tot_s2;
	logic [PROD_BITS-1:0]   prod_s3;
	logic                   out_vld_q;
	logic                   warm_out_q;
	logic [FIELD_BITS-1:0]  filt_q;

	logic rdy_1, rdy_2, rdy_3, rdy_out;
	logic in_acc;
	logic avg_upd;

	// a stage can load when empty or when its word moves on
	assign rdy_out = !out_vld_q || !out_stall;
	assign rdy_3   = !ctl_s3.vld || rdy_out;
	assign rdy_2   = !ctl_s2.vld || rdy_3;
	assign rdy_1   = !ctl_s1.vld || rdy_2;

	assign in_stall = !rdy_1;
	assign in_acc   = in_valid && rdy_1;
	assign s_in     = SAMPLE_BITS'(sample);
	assign warm_now = warm_cnt_q < WARM_DONE;
	assign avg_upd  = ctl_s1.vld && !ctl_s1.warm && rdy_2;

	mtmaf_median #(
		.MEDIAN_TAPS(MEDIAN_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.START_LEVEL(START_LEVEL)
	) u_median (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (in_acc),
		.sample(s_in),
		.median(med)
	);

	mtmaf_average #(
		.AVERAGE_TAPS(AVERAGE_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.START_LEVEL (START_LEVEL),
		.TOTAL_BITS  (TOTAL_BITS)
	) u_average (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (avg_upd),
		.median   (med_s1),
		.total_nxt(total_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_cnt_q <= '0;
		end else if (in_acc && warm_now) begin
			warm_cnt_q <= warm_cnt_q + WCW'(1);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy_1) begin
				ctl_s1.vld  <= in_acc;
				ctl_s1.warm <= warm_now;
			end
			if (rdy_2) begin
				ctl_s2 <= ctl_s1;
			end
			if (rdy_3) begin
				ctl_s3 <= ctl_s2;
			end
			if (rdy_out) begin
				out_vld_q <= ctl_s3.vld;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_s1 <= FIELD_BITS'(s_in);
			med_s1 <= med;
		end
		if (rdy_2 && ctl_s1.vld) begin
			raw_s2 <= raw_s1;
			tot_s2 <= total_nxt;
		end
		if (rdy_3 && ctl_s2.vld) begin
			raw_s3  <= raw_s2;
			prod_s3 <= PROD_BITS'(tot_s2) * PROD_BITS'(RECIP);
		end
		if (rdy_out && ctl_s3.vld) begin
			warm_out_q <= ctl_s3.warm;
			filt_q     <= ctl_s3.warm ? raw_s3 : FIELD_BITS'(prod_s3 >> SHIFT);
		end
	end

	assign out_valid  = out_vld_q;
	assign filtered   = filt_q;
	assign warming_up = warm_out_q;

	a_warm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		warm_cnt_q <= WARM_DONE)
		else $error("warm-up count past window size");

	a_warm_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_cnt_q == WARM_DONE) |=> (warm_cnt_q == WARM_DONE))
		else $error("warm-up count left its final value");

	a_warm_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && warm_now) |=> (ctl_s1.vld && ctl_s1.warm))
		else $error("warm-up word not tagged in first stage");

	a_filtered_after_warm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !warm_out_q) |-> (warm_cnt_q == WARM_DONE))
		else $error("filtered word before warm-up finished");

endmodule
